// ===== rtl/qbm_pkg.sv =====
`default_nettype none
package qbm_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF = 16;
  localparam int CORDIC_ITERS_DEF = 16;
  localparam int NUM_REGS = 7;
  localparam int IDX_W = 3;
  localparam int HEAD_W = 16;
  localparam int ANG_W = 36;
  localparam int VEC_W = 64;
  localparam int TAB_LEN = 24;

  localparam logic [IDX_W-1:0] REG_P0X = 3'd0;
  localparam logic [IDX_W-1:0] REG_P0Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_P1X = 3'd2;
  localparam logic [IDX_W-1:0] REG_P1Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_P2X = 3'd4;
  localparam logic [IDX_W-1:0] REG_P2Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_DUR = 3'd6;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 36'sd754974720;
  localparam logic signed [ANG_W-1:0] HEAD_MAX = 36'sd23040;
  localparam logic signed [ANG_W-1:0] HEAD_MIN = -36'sd23040;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_POS, ST_NORM, ST_CORD, ST_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic start_div;
    logic div_step;
    logic do_mul;
    logic do_pos;
    logic start_norm;
    logic norm_step;
    logic cord_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic norm_done;
    logic cord_done;
  } sts_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0: v = 36'sd377487360;   5'd1: v = 36'sd222843801;
      5'd2: v = 36'sd117744544;   5'd3: v = 36'sd59768969;
      5'd4: v = 36'sd30000467;    5'd5: v = 36'sd15014858;
      5'd6: v = 36'sd7509261;     5'd7: v = 36'sd3754860;
      5'd8: v = 36'sd1877459;     5'd9: v = 36'sd938733;
      5'd10: v = 36'sd469367;     5'd11: v = 36'sd234683;
      5'd12: v = 36'sd117342;     5'd13: v = 36'sd58671;
      5'd14: v = 36'sd29335;      5'd15: v = 36'sd14668;
      5'd16: v = 36'sd7334;       5'd17: v = 36'sd3667;
      5'd18: v = 36'sd1833;       5'd19: v = 36'sd917;
      5'd20: v = 36'sd458;        5'd21: v = 36'sd229;
      5'd22: v = 36'sd115;        5'd23: v = 36'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/qbm_ctrl.sv =====
`default_nettype none
module qbm_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic go,
  input  wire qbm_pkg::sts_t sts,
  input  wire logic out_free,
  output qbm_pkg::cmd_t cmd,
  output logic busy
);
  import qbm_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (go) state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_NORM;
      ST_NORM: if (sts.norm_done) state_nxt = ST_CORD;
      ST_CORD: if (sts.cord_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin busy = 1'b0; cmd.start_div = go; end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_MUL:  cmd.do_mul = 1'b1;
      ST_POS:  begin cmd.do_pos = 1'b1; cmd.start_norm = 1'b1; end
      ST_NORM: cmd.norm_step = 1'b1;
      ST_CORD: cmd.cord_step = 1'b1;
      ST_DONE: cmd.finish = out_free;
      ST_OUT:  cmd.finish = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && go |=> state_r == ST_DIV)
    else $error("tick did not start division");
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.div_step, cmd.cord_step, cmd.norm_step}))
    else $error("overlapping datapath steps");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |=> state_r == ST_POS)
    else $error("multiply stage skipped");
endmodule
`default_nettype wire

// ===== rtl/qbm_dp.sv =====
`default_nettype none
module qbm_dp #(
  parameter int COORD_WIDTH = qbm_pkg::COORD_WIDTH_DEF,
  parameter int TIME_WIDTH = qbm_pkg::TIME_WIDTH_DEF,
  parameter int CORDIC_ITERS = qbm_pkg::CORDIC_ITERS_DEF
) (
  input  wire logic clk,
  input  wire qbm_pkg::cmd_t cmd,
  output qbm_pkg::sts_t sts,
  input  wire logic signed [COORD_WIDTH-1:0] p0x, p0y, p1x, p1y, p2x, p2y,
  input  wire logic [TIME_WIDTH-1:0] dur,
  input  wire logic [TIME_WIDTH-1:0] rem,
  output logic signed [COORD_WIDTH-1:0] pos_x_r,
  output logic signed [COORD_WIDTH-1:0] pos_y_r,
  output logic signed [qbm_pkg::HEAD_W-1:0] head_r
);
  import qbm_pkg::*;
  localparam int TW = 17;
  localparam int CW2 = COORD_WIDTH + 2;
  localparam int DW = CW2 + TW + 2;
  localparam int PW = 2 * COORD_WIDTH + 36;
  localparam int IW = $clog2(TAB_LEN + 1);

  // restoring divider, 17 quotient bits
  logic [TIME_WIDTH:0] prem_r, prem_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic [4:0] dcnt_r;
  logic [TIME_WIDTH:0] trial;

  always_comb begin
    // first step compares the plain difference, later ones shift in a zero
    trial = (dcnt_r == 5'd0) ? prem_r : {prem_r[TIME_WIDTH-1:0], 1'b0};
    prem_nxt = trial;
    t_nxt = {t_r[TW-2:0], 1'b0};
    if (trial >= {1'b0, dur}) begin
      prem_nxt = trial - {1'b0, dur};
      t_nxt = {t_r[TW-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      prem_r <= {1'b0, dur - rem};
      dcnt_r <= '0;
      if (dur == '0) t_r <= 17'h10000;
      else t_r <= '0;
    end else if (cmd.div_step && dcnt_r != 5'd17) begin
      if (dur != '0 && rem <= dur) begin
        prem_r <= prem_nxt;
        t_r <= t_nxt;
      end
      dcnt_r <= dcnt_r + 5'd1;
    end
  end
  // difference is at most the duration, so quotient bit 16 comes first
  assign sts.div_done = dcnt_r == 5'd17;

  // products
  logic [TW:0] s_w;
  logic signed [PW-1:0] bx_r, by_r, ax_r, ay_r;
  logic signed [TW+1:0] ts, ss;
  logic signed [2*TW+3:0] tt_r, st_r, ss_r;
  assign s_w = 18'h10000 - {1'b0, t_r};
  assign ts = {2'b00, t_r};
  assign ss = {1'b0, s_w};

  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      tt_r <= ts * ts;
      st_r <= 2 * ts * ss;
      ss_r <= ss * ss;
    end
  end

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [PW-1:0] a);
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] hi, lo;
    hi = PW'((1 <<< (COORD_WIDTH - 1)) - 1);
    lo = -hi - 1;
    r = (a + PW'(64'sd1 <<< 31)) >>> 32;
    if (r > hi) return hi[COORD_WIDTH-1:0];
    if (r < lo) return lo[COORD_WIDTH-1:0];
    return r[COORD_WIDTH-1:0];
  endfunction

  logic signed [VEC_W-1:0] x_r, y_r;
  logic signed [ANG_W-1:0] z_r;
  logic [IW-1:0] icnt_r;
  logic signed [VEC_W-1:0] dxw, dyw;
  logic signed [CW2-1:0] cx, cy, lx, ly;
  logic signed [DW-1:0] mx, my;

  // half the derivative scaled by 2^16
  assign cx = CW2'(p0x) - CW2'(p1x) - CW2'(p1x) + CW2'(p2x);
  assign cy = CW2'(p0y) - CW2'(p1y) - CW2'(p1y) + CW2'(p2y);
  assign lx = CW2'(p1x) - CW2'(p0x);
  assign ly = CW2'(p1y) - CW2'(p0y);
  assign mx = DW'(cx) * DW'(ts);
  assign my = DW'(cy) * DW'(ts);
  assign dxw = VEC_W'(mx) + (VEC_W'(lx) <<< 16);
  assign dyw = VEC_W'(my) + (VEC_W'(ly) <<< 16);

  always_ff @(posedge clk) begin
    if (cmd.do_pos) begin
      pos_x_r <= sat(PW'(ss_r) * p0x + PW'(st_r) * p1x + PW'(tt_r) * p2x);
      pos_y_r <= sat(PW'(ss_r) * p0y + PW'(st_r) * p1y + PW'(tt_r) * p2y);
    end
  end

  logic zero_r;
  logic big;
  assign big = (x_r >= (64'sd1 <<< 40)) || (x_r <= -(64'sd1 <<< 40)) ||
               (y_r >= (64'sd1 <<< 40)) || (y_r <= -(64'sd1 <<< 40));
  assign sts.norm_done = zero_r || big;
  assign sts.cord_done = zero_r || icnt_r == IW'(CORDIC_ITERS);

  logic signed [ANG_W-1:0] h;
  assign h = (-z_r + 36'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (cmd.start_norm) begin
      x_r <= -dyw;
      y_r <= dxw;
      z_r <= '0;
      icnt_r <= '0;
      zero_r <= dxw == '0 && dyw == '0;
    end else if (cmd.norm_step && !sts.norm_done) begin
      x_r <= x_r <<< 1;
      y_r <= y_r <<< 1;
    end else if (cmd.norm_step) begin
      if (x_r < 0) begin
        if (y_r >= 0) begin x_r <= y_r; y_r <= -x_r; z_r <= QUARTER_TURN; end
        else begin x_r <= -y_r; y_r <= x_r; z_r <= -QUARTER_TURN; end
      end
    end else if (cmd.cord_step && !sts.cord_done) begin
      if (y_r >= 0) begin
        x_r <= x_r + (y_r >>> icnt_r);
        y_r <= y_r - (x_r >>> icnt_r);
        z_r <= z_r + atan_lut(5'(icnt_r));
      end else begin
        x_r <= x_r - (y_r >>> icnt_r);
        y_r <= y_r + (x_r >>> icnt_r);
        z_r <= z_r - atan_lut(5'(icnt_r));
      end
      icnt_r <= icnt_r + 1'b1;
    end else if (cmd.cord_step) begin
      if (zero_r) head_r <= '0;
      else if (h > HEAD_MAX) head_r <= HEAD_MAX[HEAD_W-1:0];
      else if (h < HEAD_MIN) head_r <= HEAD_MIN[HEAD_W-1:0];
      else head_r <= h[HEAD_W-1:0];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/quadratic_bezier_mover.sv =====
// steps: a tick item passes the 17-step divider, products, position, tangent normalization
//   by doubling and the cordic loop; a zero tangent ends both loops at once
// flow: no new item is taken until the result is in the output register; start items
//   also wait while busy; the result waits in its own register
// reset (rst_n low, synchronous): control points zero, duration one, remaining time zero
`default_nettype none
module quadratic_bezier_mover #(
  parameter int COORD_WIDTH = qbm_pkg::COORD_WIDTH_DEF,
  parameter int TIME_WIDTH = qbm_pkg::TIME_WIDTH_DEF,
  parameter int CORDIC_ITERS = qbm_pkg::CORDIC_ITERS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic [15:0] in_tdata,   // time_step
  input  wire logic in_tuser,          // req_type
  output logic out_tvalid,
  input  wire logic out_tready,
  output logic [2*COORD_WIDTH+15:0] out_tdata, // pos_x, pos_y, heading
  output logic out_tuser,             // finished
  input  wire logic cfg_we,
  input  wire logic [qbm_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [(COORD_WIDTH > TIME_WIDTH ? COORD_WIDTH : TIME_WIDTH)-1:0] cfg_wdata
);
  import qbm_pkg::*;
  logic signed [COORD_WIDTH-1:0] p_r [6];
  logic [TIME_WIDTH-1:0] dur_r, rem_r;
  logic [15:0] step_r;
  logic fin_r;
  cmd_t cmd;
  sts_t sts;
  logic busy, go;
  logic signed [COORD_WIDTH-1:0] px, py;
  logic signed [HEAD_W-1:0] hd;

  assign in_tready = !busy;
  assign go = in_tvalid && in_tready && in_tuser == REQ_TICK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) p_r[i] <= '0;
      dur_r <= TIME_WIDTH'(1);
      rem_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index < REG_DUR) p_r[cfg_index] <= cfg_wdata[COORD_WIDTH-1:0];
      if (cfg_we && cfg_index == REG_DUR) dur_r <= cfg_wdata[TIME_WIDTH-1:0];
      if (in_tvalid && in_tready && in_tuser == REQ_START) rem_r <= dur_r;
      if (go) begin step_r <= in_tdata; fin_r <= rem_r == '0; end
      if (cmd.finish) begin
        out_tvalid <= 1'b1;
        out_tdata <= {hd, py, px};
        out_tuser <= fin_r;
        if (rem_r != '0)
          rem_r <= (TIME_WIDTH'(step_r) >= rem_r) ? '0 : rem_r - TIME_WIDTH'(step_r);
      end else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
    end
  end

  qbm_ctrl u_ctrl (.clk, .rst_n, .go, .sts, .out_free(!out_tvalid || out_tready),
    .cmd, .busy);

  qbm_dp #(.COORD_WIDTH(COORD_WIDTH), .TIME_WIDTH(TIME_WIDTH),
    .CORDIC_ITERS(CORDIC_ITERS)) u_dp (
    .clk, .cmd, .sts,
    .p0x(p_r[0]), .p0y(p_r[1]), .p1x(p_r[2]), .p1y(p_r[3]), .p2x(p_r[4]), .p2y(p_r[5]),
    .dur(dur_r), .rem(rem_r), .pos_x_r(px), .pos_y_r(py), .head_r(hd));

  assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !out_tvalid || !$past(cmd.finish))
    else $error("tick accepted during result");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("waiting result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_tvalid)
    else $error("result lost");
endmodule
`default_nettype wire
